/* design/nnis_pkg.sv */
// Shared types and constants of the nearest-neighbor image scaler.
package nnis_pkg;

	localparam int COORD_W   = 12;
	localparam int PIX_W     = 32;
	localparam int SRC_DIM_W = 9;
	localparam int DST_DIM_W = 13;
	localparam int PROD_W    = COORD_W + SRC_DIM_W;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_DST_HEIGHT = 2'd3;

	localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 9'd256;
	localparam logic [DST_DIM_W-1:0] DST_DIM_RESET = 13'd256;

	typedef struct packed {
		logic               req_type;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   pixel_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             coord_error;
	} rsp_t;

endpackage

/* design/nnis_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module nnis_div #(
	parameter int QW = 8,
	parameter int NW = 21,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] quo_s [QW];

	logic [DW-1:0] rem_in [QW];
	logic [DW-1:0] den_in [QW];
	logic [QW-1:0] low_in [QW];
	logic [QW-1:0] quo_in [QW];
	logic [DW-1:0] rem_nx [QW];
	logic [QW-1:0] quo_nx [QW];

	// The caller guarantees num < den * 2**QW, so the upper part of the
	// numerator is already a valid partial remainder.
	always_comb begin
		logic [DW:0] trial;
		logic        ge;
		trial = '0;
		ge = 1'b0;
		rem_in[0] = DW'(num >> QW);
		den_in[0] = den;
		low_in[0] = num[QW-1:0];
		quo_in[0] = '0;
		for (int k = 1; k < QW; k++) begin
			rem_in[k] = rem_s[k-1];
			den_in[k] = den_s[k-1];
			low_in[k] = low_s[k-1];
			quo_in[k] = quo_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial = {rem_in[k], low_in[k][QW-1-k]};
			ge = trial >= {1'b0, den_in[k]};
			rem_nx[k] = ge ? DW'(trial - {1'b0, den_in[k]}) : DW'(trial);
			quo_nx[k] = quo_in[k];
			quo_nx[k][QW-1-k] = ge;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QW; k++) begin
			rem_s[k] <= rem_nx[k];
			den_s[k] <= den_in[k];
			low_s[k] <= low_in[k];
			quo_s[k] <= quo_nx[k];
		end
	end

	assign quo = quo_s[QW-1];

endmodule

/* design/nearest_neighbor_image_scaler.sv */
// Nearest-neighbor image scaler: pixel store, coordinate mapping pipeline and result register.
// The block takes one word per clock with no gaps: busy is always low. A load inside the source
// size writes a source pixel; a fetch returns one resampled pixel on rsp with done high for
// exactly one cycle, or a zero pixel with coord_error set when it lies outside the output size.
// The dividers resolve one quotient bit per stage, and the single-port pixel store sees one load
// or one fetch per cycle in accept order, so a fetch always sees every earlier load. The
// receiver cannot stall, so results must be taken as they come. The store has no clearing
// pass; fetching a pixel that was never loaded gives an unspecified value.
module nearest_neighbor_image_scaler #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  nnis_pkg::req_t                   req,
	input  logic                             cfg_we,
	input  logic [nnis_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [nnis_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                             done,
	output nnis_pkg::rsp_t                   rsp
);

	localparam int XW = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int YW = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
	localparam int QW = (XW > YW) ? XW : YW;
	localparam int CMPW = ((QW + 1) > nnis_pkg::SRC_DIM_W) ? (QW + 1) : nnis_pkg::SRC_DIM_W;
	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LAT = QW + 5;

	typedef struct packed {
		logic                               fetch;
		logic                               load;
		logic                               err;
		logic [nnis_pkg::COORD_W-1:0]       col;
		logic [nnis_pkg::COORD_W-1:0]       row;
		logic [nnis_pkg::PIX_W-1:0]         pixel;
	} side_t;

	logic [nnis_pkg::SRC_DIM_W-1:0] src_width_q, src_height_q;
	logic [nnis_pkg::DST_DIM_W-1:0] dst_width_q, dst_height_q;
	logic [nnis_pkg::SRC_DIM_W-1:0] sw_eff, sh_eff;
	logic [nnis_pkg::DST_DIM_W-1:0] dw_eff, dh_eff;

	logic accept, is_fetch, fetch_oor, load_ok;

	side_t                          side_s1;
	logic [nnis_pkg::PROD_W-1:0]    prod_x_s1, prod_y_s1;
	side_t                          side_q [QW];
	logic [QW-1:0]                  quo_x, quo_y;

	logic                           fetch_s3, load_s3, err_s3;
	logic [XW-1:0]                  sx_s3;
	logic [YW-1:0]                  sy_s3;
	logic [nnis_pkg::PIX_W-1:0]     pixel_s3;

	logic                           fetch_s4, load_s4, err_s4;
	logic [AW-1:0]                  addr_s4;
	logic [nnis_pkg::PIX_W-1:0]     pixel_s4;

	logic                           fetch_s5, err_s5;
	logic [nnis_pkg::PIX_W-1:0]     rdata_s5;

	logic [nnis_pkg::PIX_W-1:0]     mem [DEPTH];

	logic                           done_q;
	nnis_pkg::rsp_t                 rsp_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= nnis_pkg::SRC_DIM_RESET;
			src_height_q <= nnis_pkg::SRC_DIM_RESET;
			dst_width_q  <= nnis_pkg::DST_DIM_RESET;
			dst_height_q <= nnis_pkg::DST_DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				nnis_pkg::CFG_SRC_WIDTH: begin
					src_width_q <= cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
				end
				nnis_pkg::CFG_SRC_HEIGHT: begin
					src_height_q <= cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
				end
				nnis_pkg::CFG_DST_WIDTH: begin
					dst_width_q <= cfg_wdata;
				end
				nnis_pkg::CFG_DST_HEIGHT: begin
					dst_height_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// A zero size acts as one; a source size above the store limit acts as the limit.
	always_comb begin
		if (src_width_q == '0) begin
			sw_eff = nnis_pkg::SRC_DIM_W'(1);
		end else if (CMPW'(src_width_q) > CMPW'(MAX_SRC_WIDTH)) begin
			sw_eff = nnis_pkg::SRC_DIM_W'(MAX_SRC_WIDTH);
		end else begin
			sw_eff = src_width_q;
		end
		if (src_height_q == '0) begin
			sh_eff = nnis_pkg::SRC_DIM_W'(1);
		end else if (CMPW'(src_height_q) > CMPW'(MAX_SRC_HEIGHT)) begin
			sh_eff = nnis_pkg::SRC_DIM_W'(MAX_SRC_HEIGHT);
		end else begin
			sh_eff = src_height_q;
		end
		dw_eff = (dst_width_q == '0) ? nnis_pkg::DST_DIM_W'(1) : dst_width_q;
		dh_eff = (dst_height_q == '0) ? nnis_pkg::DST_DIM_W'(1) : dst_height_q;
	end

	assign is_fetch = req.req_type == nnis_pkg::REQ_FETCH;
	assign fetch_oor = nnis_pkg::DST_DIM_W'(req.col) >= dw_eff
		|| nnis_pkg::DST_DIM_W'(req.row) >= dh_eff;
	assign load_ok = req.col < nnis_pkg::COORD_W'(sw_eff)
		&& req.row < nnis_pkg::COORD_W'(sh_eff);

	// Loads and out-of-range fetches feed zero to the dividers so that the
	// numerator always stays below the divisor times the quotient range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1.fetch <= accept && is_fetch;
			side_s1.load  <= accept && !is_fetch && load_ok;
			side_s1.err   <= is_fetch && fetch_oor;
			side_s1.col   <= req.col;
			side_s1.row   <= req.row;
			side_s1.pixel <= req.pixel_in;
		end
	end

	always_ff @(posedge clk) begin
		if (is_fetch && !fetch_oor) begin
			prod_x_s1 <= nnis_pkg::PROD_W'(req.col) * nnis_pkg::PROD_W'(sw_eff);
			prod_y_s1 <= nnis_pkg::PROD_W'(req.row) * nnis_pkg::PROD_W'(sh_eff);
		end else begin
			prod_x_s1 <= '0;
			prod_y_s1 <= '0;
		end
	end

	nnis_div #(
		.QW(QW),
		.NW(nnis_pkg::PROD_W),
		.DW(nnis_pkg::DST_DIM_W)
	) u_div_x (
		.clk(clk),
		.num(prod_x_s1),
		.den(dw_eff),
		.quo(quo_x)
	);

	nnis_div #(
		.QW(QW),
		.NW(nnis_pkg::PROD_W),
		.DW(nnis_pkg::DST_DIM_W)
	) u_div_y (
		.clk(clk),
		.num(prod_y_s1),
		.den(dh_eff),
		.quo(quo_y)
	);

	// Side information travels alongside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				side_q[k] <= '0;
			end
		end else begin
			side_q[0] <= side_s1;
			for (int k = 1; k < QW; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s3 <= 1'b0;
			load_s3  <= 1'b0;
			err_s3   <= 1'b0;
		end else begin
			fetch_s3 <= side_q[QW-1].fetch;
			load_s3  <= side_q[QW-1].load;
			err_s3   <= side_q[QW-1].err;
		end
	end

	always_ff @(posedge clk) begin
		pixel_s3 <= side_q[QW-1].pixel;
		if (side_q[QW-1].fetch) begin
			if (CMPW'(quo_x) > CMPW'(sw_eff - nnis_pkg::SRC_DIM_W'(1))) begin
				sx_s3 <= XW'(sw_eff - nnis_pkg::SRC_DIM_W'(1));
			end else begin
				sx_s3 <= XW'(quo_x);
			end
			if (CMPW'(quo_y) > CMPW'(sh_eff - nnis_pkg::SRC_DIM_W'(1))) begin
				sy_s3 <= YW'(sh_eff - nnis_pkg::SRC_DIM_W'(1));
			end else begin
				sy_s3 <= YW'(quo_y);
			end
		end else begin
			sx_s3 <= XW'(side_q[QW-1].col);
			sy_s3 <= YW'(side_q[QW-1].row);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s4 <= 1'b0;
			load_s4  <= 1'b0;
			err_s4   <= 1'b0;
		end else begin
			fetch_s4 <= fetch_s3;
			load_s4  <= load_s3;
			err_s4   <= err_s3;
		end
	end

	always_ff @(posedge clk) begin
		addr_s4  <= AW'(sy_s3) * AW'(MAX_SRC_WIDTH) + AW'(sx_s3);
		pixel_s4 <= pixel_s3;
	end

	// One access per cycle, in accept order, so loads and fetches never race.
	always_ff @(posedge clk) begin
		if (load_s4) begin
			mem[addr_s4] <= pixel_s4;
		end
		if (fetch_s4) begin
			rdata_s5 <= mem[addr_s4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s5 <= 1'b0;
			err_s5   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			fetch_s5 <= fetch_s4;
			err_s5   <= err_s4;
			done_q   <= fetch_s5;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.pixel_out   <= err_s5 ? '0 : rdata_s5;
		rsp_q.coord_error <= err_s5;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && req.req_type == nnis_pkg::REQ_FETCH, LAT))
		else $error("result word without a matching fetch");

	a_quo_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		side_q[QW-1].fetch |-> CMPW'(quo_x) < CMPW'(sw_eff))
		else $error("column quotient beyond source width");

	a_quo_y_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		side_q[QW-1].fetch |-> CMPW'(quo_y) < CMPW'(sh_eff))
		else $error("row quotient beyond source height");

	a_addr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s4 || fetch_s4) |-> (32'(addr_s4) < 32'(DEPTH)))
		else $error("pixel store address out of range");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the nearest-neighbor image scaler.
module tb_top;

	localparam int MAX_W        = 256;
	localparam int MAX_H        = 256;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_WORDS  = 70;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	nnis_pkg::req_t                  req;
	logic                            cfg_we;
	logic [nnis_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                            done;
	nnis_pkg::rsp_t                  rsp;

	nearest_neighbor_image_scaler #(
		.MAX_SRC_WIDTH(MAX_W),
		.MAX_SRC_HEIGHT(MAX_H)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// Predictor state: geometry registers as written and a copy of the pixel store.
	logic [nnis_pkg::SRC_DIM_W-1:0] reg_src_w;
	logic [nnis_pkg::SRC_DIM_W-1:0] reg_src_h;
	logic [nnis_pkg::DST_DIM_W-1:0] reg_dst_w;
	logic [nnis_pkg::DST_DIM_W-1:0] reg_dst_h;
	logic [nnis_pkg::PIX_W-1:0]     src_image [0:MAX_W*MAX_H-1];
	bit                             loaded [0:MAX_W*MAX_H-1];
	int unsigned                    loaded_addrs[$];
	nnis_pkg::rsp_t                 pixel_expect[$];

	int unsigned    cycle_count;
	int unsigned    fail_count;
	int unsigned    words_used;
	int unsigned    fetch_count;
	int unsigned    range_errors;
	int unsigned    results_seen;
	int unsigned    geometry_count;
	int             burst_left;
	nnis_pkg::rsp_t head;

	function automatic void flag_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic int unsigned eff_dim(input int unsigned v, input int unsigned cap);
		if (v == 0)
			return 1;
		if (v > cap)
			return cap;
		return v;
	endfunction

	function automatic int unsigned map_coord(input int unsigned pos, input int unsigned src,
			input int unsigned dst);
		longint unsigned q;
		q = (64'(pos) * 64'(src)) / 64'(dst);
		if (q > 64'(src - 1))
			q = 64'(src - 1);
		return 32'(q);
	endfunction

	function automatic int unsigned src_w_eff();
		return eff_dim(32'(reg_src_w), MAX_W);
	endfunction

	function automatic int unsigned src_h_eff();
		return eff_dim(32'(reg_src_h), MAX_H);
	endfunction

	function automatic int unsigned dst_w_eff();
		return eff_dim(32'(reg_dst_w), 32'hFFFF_FFFF);
	endfunction

	function automatic int unsigned dst_h_eff();
		return eff_dim(32'(reg_dst_h), 32'hFFFF_FFFF);
	endfunction

	function automatic int unsigned fetch_addr(input int unsigned c, input int unsigned r);
		return map_coord(r, src_h_eff(), dst_h_eff()) * MAX_W
			+ map_coord(c, src_w_eff(), dst_w_eff());
	endfunction

	// A fetch is safe when it misses the output image or lands on a loaded pixel.
	function automatic bit fetch_safe(input int unsigned c, input int unsigned r);
		if (c >= dst_w_eff() || r >= dst_h_eff())
			return 1'b1;
		return loaded[fetch_addr(c, r)];
	endfunction

	// Updates the pixel store copy and queues the expected result word for a fetch.
	task automatic account_word(input nnis_pkg::req_t w);
		int unsigned    addr;
		nnis_pkg::rsp_t exp;
		if (w.req_type == nnis_pkg::REQ_LOAD) begin
			if (32'(w.col) < src_w_eff() && 32'(w.row) < src_h_eff()) begin
				addr = 32'(w.row) * MAX_W + 32'(w.col);
				src_image[addr] = w.pixel_in;
				if (!loaded[addr]) begin
					loaded[addr] = 1'b1;
					loaded_addrs.push_back(addr);
				end
				words_used++;
			end
		end else begin
			fetch_count++;
			words_used++;
			if (32'(w.col) >= dst_w_eff() || 32'(w.row) >= dst_h_eff()) begin
				exp.pixel_out = '0;
				exp.coord_error = 1'b1;
				range_errors++;
			end else begin
				exp.pixel_out = src_image[fetch_addr(32'(w.col), 32'(w.row))];
				exp.coord_error = 1'b0;
			end
			pixel_expect.push_back(exp);
		end
	endtask

	// Sends one word; start stays high through a burst and drops for a random gap between bursts.
	task automatic send_word(input nnis_pkg::req_t w);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		account_word(w);
	endtask

	task automatic load_pixel(input int unsigned c, input int unsigned r,
			input logic [nnis_pkg::PIX_W-1:0] pix);
		nnis_pkg::req_t w;
		w.req_type = nnis_pkg::REQ_LOAD;
		w.col = nnis_pkg::COORD_W'(c);
		w.row = nnis_pkg::COORD_W'(r);
		w.pixel_in = pix;
		send_word(w);
	endtask

	task automatic fetch_pixel(input int unsigned c, input int unsigned r);
		nnis_pkg::req_t w;
		w.req_type = nnis_pkg::REQ_FETCH;
		w.col = nnis_pkg::COORD_W'(c);
		w.row = nnis_pkg::COORD_W'(r);
		w.pixel_in = $urandom;
		send_word(w);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		while (pixel_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four geometry registers on consecutive cycles; the block must be idle.
	task automatic set_geometry(input int unsigned sw, input int unsigned sh,
			input int unsigned dw, input int unsigned dh);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= nnis_pkg::CFG_SRC_WIDTH;
		cfg_wdata <= nnis_pkg::CFG_DATA_W'(sw);
		@(negedge clk);
		cfg_addr <= nnis_pkg::CFG_SRC_HEIGHT;
		cfg_wdata <= nnis_pkg::CFG_DATA_W'(sh);
		@(negedge clk);
		cfg_addr <= nnis_pkg::CFG_DST_WIDTH;
		cfg_wdata <= nnis_pkg::CFG_DATA_W'(dw);
		@(negedge clk);
		cfg_addr <= nnis_pkg::CFG_DST_HEIGHT;
		cfg_wdata <= nnis_pkg::CFG_DATA_W'(dh);
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_src_w = nnis_pkg::SRC_DIM_W'(sw);
		reg_src_h = nnis_pkg::SRC_DIM_W'(sh);
		reg_dst_w = nnis_pkg::DST_DIM_W'(dw);
		reg_dst_h = nnis_pkg::DST_DIM_W'(dh);
		geometry_count++;
	endtask

	// Looks for an in-range fetch that lands on a loaded pixel, either by random draw or by
	// working back from a loaded source pixel to the first output position that maps onto it.
	task automatic pick_fetch(output nnis_pkg::req_t w, output bit found);
		int unsigned sw, sh, dw, dh, cw, ch, c, r, sx, sy, addr;
		sw = src_w_eff();
		sh = src_h_eff();
		dw = dst_w_eff();
		dh = dst_h_eff();
		cw = (dw > 4096) ? 4096 : dw;
		ch = (dh > 4096) ? 4096 : dh;
		found = 1'b0;
		w.req_type = nnis_pkg::REQ_FETCH;
		w.pixel_in = $urandom;
		for (int i = 0; i < 16 && !found; i++) begin
			if (i % 2 == 0 || loaded_addrs.size() == 0) begin
				c = $urandom_range(0, cw - 1);
				r = $urandom_range(0, ch - 1);
			end else begin
				addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
				sx = addr % MAX_W;
				sy = addr / MAX_W;
				if (sx >= sw || sy >= sh)
					continue;
				c = (sx * dw + sw - 1) / sw;
				r = (sy * dh + sh - 1) / sh;
				if (c >= cw || r >= ch)
					continue;
			end
			if (loaded[fetch_addr(c, r)]) begin
				w.col = nnis_pkg::COORD_W'(c);
				w.row = nnis_pkg::COORD_W'(r);
				found = 1'b1;
			end
		end
	endtask

	task automatic random_word();
		nnis_pkg::req_t w;
		bit             found;
		int unsigned    pick;
		pick = $urandom_range(0, 99);
		found = 1'b0;
		if (pick < 55)
			pick_fetch(w, found);
		if (!found && pick >= 85) begin
			// Noise: any coordinates; a fetch that would read an unloaded pixel becomes a load.
			w.req_type = 1'($urandom_range(0, 1));
			w.col = nnis_pkg::COORD_W'($urandom_range(0, 4095));
			w.row = nnis_pkg::COORD_W'($urandom_range(0, 4095));
			w.pixel_in = $urandom;
			if (w.req_type == nnis_pkg::REQ_FETCH && !fetch_safe(32'(w.col), 32'(w.row)))
				w.req_type = nnis_pkg::REQ_LOAD;
			found = 1'b1;
		end
		if (!found) begin
			w.req_type = nnis_pkg::REQ_LOAD;
			w.col = nnis_pkg::COORD_W'($urandom_range(0, src_w_eff() - 1));
			w.row = nnis_pkg::COORD_W'($urandom_range(0, src_h_eff() - 1));
			w.pixel_in = $urandom;
		end
		send_word(w);
	endtask

	task automatic run_phase(input int unsigned budget);
		int unsigned target;
		if (src_w_eff() * src_h_eff() <= 64) begin
			for (int r = 0; r < src_h_eff(); r++)
				for (int c = 0; c < src_w_eff(); c++)
					load_pixel(c, r, $urandom);
		end else begin
			repeat (48)
				load_pixel($urandom_range(0, src_w_eff() - 1),
					$urandom_range(0, src_h_eff() - 1), $urandom);
		end
		target = words_used + budget;
		while (words_used < target)
			random_word();
	endtask

	task automatic test_reset_geometry();
		load_pixel(0, 0, 32'hFFFF_FFFF);
		load_pixel(255, 255, 32'h0000_0000);
		load_pixel(255, 0, 32'hA5A5_A5A5);
		load_pixel(0, 255, 32'h5A5A_5A5A);
		load_pixel(256, 0, 32'h1111_1111);
		load_pixel(0, 4095, 32'h2222_2222);
		fetch_pixel(0, 0);
		fetch_pixel(255, 255);
		fetch_pixel(255, 0);
		fetch_pixel(0, 255);
		fetch_pixel(256, 0);
		fetch_pixel(4095, 4095);
	endtask

	// Zero in every size register behaves as a one-pixel image on both sides.
	task automatic test_degenerate_geometry();
		wait_idle();
		set_geometry(0, 0, 0, 0);
		load_pixel(0, 0, 32'h1234_5678);
		load_pixel(1, 0, 32'h8765_4321);
		fetch_pixel(0, 0);
		fetch_pixel(0, 1);
		fetch_pixel(4095, 0);
	endtask

	// Source sizes beyond the store saturate; the widest output register exceeds any column.
	task automatic test_oversize_geometry();
		wait_idle();
		set_geometry(511, 300, 8191, 4096);
		load_pixel(127, 255, $urandom);
		load_pixel(255, 255, $urandom);
		fetch_pixel(4095, 4095);
		fetch_pixel(0, 0);
	endtask

	task automatic test_random_geometries();
		int unsigned geo [0:8][0:3] = '{
			'{4, 3, 9, 7}, '{16, 16, 5, 5}, '{1, 1, 4096, 4096}, '{256, 256, 1, 1},
			'{256, 256, 4096, 4096}, '{13, 200, 13, 17}, '{7, 1, 4095, 2},
			'{2, 256, 3, 300}, '{256, 1, 256, 1}
		};
		for (int p = 0; p < 9; p++) begin
			wait_idle();
			set_geometry(geo[p][0], geo[p][1], geo[p][2], geo[p][3]);
			run_phase(PHASE_WORDS);
		end
		repeat (3) begin
			wait_idle();
			set_geometry($urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 8191), $urandom_range(0, 8191));
			run_phase(PHASE_WORDS);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pixel_expect.size() == 0) begin
				flag_failure($sformatf("unexpected result word: pixel_out %h coord_error %0b",
					rsp.pixel_out, rsp.coord_error));
			end else begin
				head = pixel_expect.pop_front();
				results_seen++;
				if (rsp.pixel_out !== head.pixel_out)
					flag_failure($sformatf("pixel_out mismatch: expected %h got %h",
						head.pixel_out, rsp.pixel_out));
				if (rsp.coord_error !== head.coord_error)
					flag_failure($sformatf("coord_error mismatch: expected %0b got %0b",
						head.coord_error, rsp.coord_error));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL nearest_neighbor_image_scaler");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_addr = nnis_pkg::CFG_SRC_WIDTH;
		cfg_wdata = '0;
		burst_left = 0;
		reg_src_w = nnis_pkg::SRC_DIM_RESET;
		reg_src_h = nnis_pkg::SRC_DIM_RESET;
		reg_dst_w = nnis_pkg::DST_DIM_RESET;
		reg_dst_h = nnis_pkg::DST_DIM_RESET;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_geometry();
		test_degenerate_geometry();
		test_oversize_geometry();
		test_random_geometries();

		wait_idle();
		if (pixel_expect.size() != 0)
			flag_failure($sformatf("%0d result words never arrived", pixel_expect.size()));
		$display("Sent %0d effective words (%0d fetches, %0d outside the output image)",
			words_used, fetch_count, range_errors);
		$display("over %0d geometries; checked %0d result words, %0d failures.",
			geometry_count, results_seen, fail_count);
		if (fail_count == 0)
			$display("PASS nearest_neighbor_image_scaler");
		else
			$display("FAIL nearest_neighbor_image_scaler");
		$finish;
	end

endmodule

/* files.f */
design/nnis_pkg.sv
design/nnis_div.sv
design/nearest_neighbor_image_scaler.sv
tb/tb_top.sv
